FILE: hdl/ukc_pkg.sv
// shared types and constants for the utf-8 to kana code stream block
package ukc_pkg;

  // code point range and normalisation constants
  localparam logic [20:0] KATA_LO     = 21'h030A1;
  localparam logic [20:0] KATA_HI     = 21'h030F6;
  localparam logic [20:0] KATA_OFFSET = 21'h00060;
  localparam logic [20:0] LONG_MARK   = 21'h030FC;
  localparam logic [20:0] LONG_HIRA   = 21'h03046;
  localparam logic [20:0] HIRA_LO     = 21'h03041;
  localparam logic [20:0] HIRA_HI     = 21'h03093;
  localparam logic [20:0] HIRA_BASE   = 21'h03040;
  localparam logic [20:0] REPLACEMENT = 21'h0FFFD;

  // counter saturation value of the 7 bit code count
  localparam logic [6:0] COUNT_MAX = 7'd127;

  // decoded code point handed from the byte decoder to the kana mapper
  typedef struct packed {
    logic        have_point;
    logic [20:0] point;
  } ukc_point_t;

endpackage

FILE: hdl/ukc_decode.sv
// utf-8 byte decoder: lead byte classification and continuation accumulation
module ukc_decode
  import ukc_pkg::*;
(
  input  logic [7:0]  text_byte,
  input  logic [1:0]  pending,
  input  logic [20:0] accum,
  output logic [1:0]  pending_nxt,
  output logic [20:0] accum_nxt,
  output ukc_point_t  dec
);

  logic [20:0] shifted;

  // continuation bytes only contribute their low six bits
  assign shifted = {accum[14:0], text_byte[5:0]};

  always_comb begin
    pending_nxt    = pending;
    accum_nxt      = accum;
    dec.have_point = 1'b0;
    dec.point      = '0;
    if (pending == 2'd0) begin
      // lead byte
      if (text_byte[7] == 1'b0) begin
        dec.have_point = 1'b1;
        dec.point      = {13'd0, text_byte};
      end else if (text_byte[7:5] == 3'b110) begin
        accum_nxt   = {16'd0, text_byte[4:0]};
        pending_nxt = 2'd1;
      end else if (text_byte[7:4] == 4'b1110) begin
        accum_nxt   = {17'd0, text_byte[3:0]};
        pending_nxt = 2'd2;
      end else if (text_byte[7:3] == 5'b11110) begin
        accum_nxt   = {18'd0, text_byte[2:0]};
        pending_nxt = 2'd3;
      end else begin
        // stray continuation or invalid lead byte
        dec.have_point = 1'b1;
        dec.point      = REPLACEMENT;
      end
    end else begin
      pending_nxt = pending - 2'd1;
      if (pending == 2'd1) begin
        dec.have_point = 1'b1;
        dec.point      = shifted;
        accum_nxt      = '0;
      end else begin
        accum_nxt = shifted;
      end
    end
  end

endmodule

FILE: hdl/ukc_map.sv
// kana mapper: katakana folding and compact code lookup
module ukc_map
  import ukc_pkg::*;
(
  input  logic [20:0] point,
  output logic [6:0]  code
);

  logic [20:0] norm;
  logic [20:0] diff;

  // fold katakana and the long mark onto hiragana
  always_comb begin
    norm = point;
    if (point >= KATA_LO && point <= KATA_HI) begin
      norm = point - KATA_OFFSET;
    end else if (point == LONG_MARK) begin
      norm = LONG_HIRA;
    end
  end

  // hiragana block to codes 1..83, everything else to zero
  assign diff = norm - HIRA_BASE;
  assign code = (norm >= HIRA_LO && norm <= HIRA_HI) ? diff[6:0] : 7'd0;

endmodule

FILE: hdl/utf8_kana_code_stream.sv
// top level: utf-8 byte stream to compact kana codes
//
// channel | dir | tdata                              | tuser       | tlast
// in_     | in  | [7:0] text_byte                    | -           | text_last
// out_    | out | [6:0] kana_index, [13:7] total_codes | index_valid | text_done
//
// one byte item per cycle sustained while results are accepted; an item waits in the
// input register and is decoded, mapped and counted on its way to the result register
// the result is registered: an accepted byte passes the input register and then the
// result register before it can be accepted at the output
// synchronous active-low reset clears decoder state, counter and valid flags
// a stalled result holds a full input register; an empty input register can still take a byte
module utf8_kana_code_stream
  import ukc_pkg::*;
#(
  parameter int CODE_LIMIT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [6:0] kana_index, [13:7] total_codes, [15:14] zero
  output logic        out_tuser,  // [0] index_valid
  output logic        out_tlast
);

  localparam int         CAP_INT = (CODE_LIMIT < 127) ? CODE_LIMIT : 127;
  localparam logic [6:0] CAP     = 7'(CAP_INT);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;

  logic [1:0]  pending_r;
  logic [20:0] accum_r;
  logic [6:0]  count_r;

  logic        out_valid_r;
  logic [6:0]  out_code_r;
  logic        out_flag_r;
  logic        out_done_r;
  logic [6:0]  out_total_r;

  logic [1:0]  pending_nxt;
  logic [20:0] accum_nxt;
  ukc_point_t  dec;
  logic [6:0]  code;
  logic        advance;
  logic        proc;
  logic        emit;
  logic [6:0]  count_nxt;

  // stage handshakes
  assign advance   = !out_valid_r || out_tready;
  assign proc      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  ukc_decode u_decode (
    .text_byte   (s1_byte_r),
    .pending     (pending_r),
    .accum       (accum_r),
    .pending_nxt (pending_nxt),
    .accum_nxt   (accum_nxt),
    .dec         (dec)
  );

  ukc_map u_map (
    .point (dec.point),
    .code  (code)
  );

  // emit decision and running count
  assign emit      = dec.have_point && (code != 7'd0) && (count_r < CAP) &&
                     (count_r < COUNT_MAX);
  assign count_nxt = emit ? count_r + 7'd1 : count_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (proc) begin
      s1_valid_r <= 1'b0;
    end
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // decoder state and code counter, cleared at the end of each text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      accum_r   <= '0;
      count_r   <= '0;
    end else if (proc) begin
      if (s1_last_r) begin
        pending_r <= '0;
        accum_r   <= '0;
        count_r   <= '0;
      end else begin
        pending_r <= pending_nxt;
        accum_r   <= accum_nxt;
        count_r   <= count_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= proc && (emit || s1_last_r);
    end
    if (proc && (emit || s1_last_r)) begin
      out_code_r  <= emit ? code : 7'd0;
      out_flag_r  <= emit;
      out_done_r  <= s1_last_r;
      out_total_r <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_total_r, out_code_r};
  assign out_tuser  = out_flag_r;
  assign out_tlast  = out_done_r;

`ifndef ASSERT_OFF
  // a flagged result always carries a nonzero code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flag_r |-> out_code_r != 7'd0)
    else $error("flagged result without kana code");

  // a result that does not close the text must carry a code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_done_r |-> out_flag_r)
    else $error("empty result in mid text");

  // the counter never passes the limit
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP)
    else $error("code count beyond limit");

  // processing the final byte leaves the decoder clear
  assert property (@(posedge clk) disable iff (!rst_n)
    proc && s1_last_r |=> pending_r == 2'd0 && accum_r == 21'd0 && count_r == 7'd0)
    else $error("state not cleared after end of text");
`endif

endmodule
